// ===== hw/rtl/ppurp_pkg.sv =====
// types, constants and codes shared by the ppu register port files
package ppurp_pkg;

    localparam int SPRITE_MEM_DEPTH = 256;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 16;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_FLAGS = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [13:0] PALETTE_BASE = 14'h3F00;
    localparam logic [15:0] ADDR_INC_ROW = 16'd32;
    localparam logic [15:0] ADDR_INC_COL = 16'd1;

    typedef struct packed {
        func_t       func;
        logic [2:0]  reg_index;
        logic [7:0]  data;
        logic [7:0]  vram_rdata;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] mem_addr;
        logic        mem_read;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic [15:0] cur_addr;
        logic [15:0] tmp_addr;
        logic [2:0]  fine_scroll_x;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
    } rsp_t;

endpackage

// ===== hw/rtl/ppurp_ram.sv =====
// generic single-write, single-read ram with registered read data
module ppurp_ram #(
    parameter int WIDTH = ppurp_pkg::BYTE_W,
    parameter int DEPTH = ppurp_pkg::SPRITE_MEM_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/video_ppu_register_port_unit.sv =====
// top level of the ppu cpu register port
// Takes one bus request per cycle (register read, register write or a status flag update
// from rendering) and returns one response per request in the following cycle, holding
// it in an output register while the response side stalls; a new request is taken in
// every cycle unless that register is full and stalled. Each request is handled by the
// combinational register update logic; sprite memory reads come from a registered-read
// ram whose read address tracks the sprite address register, and a per-entry valid bit
// makes never-written entries read as zero right after reset, with no clearing pass.
module video_ppu_register_port_unit #(
    parameter int SPRITE_MEM_DEPTH = ppurp_pkg::SPRITE_MEM_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ppurp_pkg::cmd_t   cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ppurp_pkg::rsp_t   rsp
);

    localparam int OAM_AW = $clog2(SPRITE_MEM_DEPTH);

    logic [7:0]              control_reg, control_next;
    logic [7:0]              mask_reg, mask_next;
    logic [2:0]              status_reg, status_next;
    logic [OAM_AW-1:0]       oam_addr_reg, oam_addr_next;
    logic [7:0]              read_buf_reg, read_buf_next;
    logic [15:0]             cur_addr_reg, cur_addr_next;
    logic [15:0]             tmp_addr_reg, tmp_addr_next;
    logic [2:0]              fine_x_reg, fine_x_next;
    logic                    latch_reg, latch_next;
    logic [SPRITE_MEM_DEPTH-1:0] oam_valid_reg, oam_valid_next;
    logic                    oam_rvalid_reg;
    logic                    rsp_valid_reg;
    ppurp_pkg::rsp_t         rsp_reg, rsp_next;

    logic                    accept;
    logic                    oam_we;
    logic [7:0]              oam_rdata;
    logic [15:0]             addr_inc;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign addr_inc  = control_reg[2] ? ppurp_pkg::ADDR_INC_ROW : ppurp_pkg::ADDR_INC_COL;

    always_comb
    begin
        control_next   = control_reg;
        mask_next      = mask_reg;
        status_next    = status_reg;
        oam_addr_next  = oam_addr_reg;
        read_buf_next  = read_buf_reg;
        cur_addr_next  = cur_addr_reg;
        tmp_addr_next  = tmp_addr_reg;
        fine_x_next    = fine_x_reg;
        latch_next     = latch_reg;
        oam_we         = 1'b0;
        rsp_next       = '0;
        if (accept)
        begin
            unique case (cmd.func)
                ppurp_pkg::FUNC_READ:
                begin
                    unique case (cmd.reg_index)
                        ppurp_pkg::REG_STATUS:
                        begin
                            rsp_next.read_data = {status_reg, 5'b00000};
                            status_next        = {1'b0, status_reg[1:0]};
                            latch_next         = 1'b0;
                        end
                        ppurp_pkg::REG_OAM_DATA:
                        begin
                            rsp_next.read_data = oam_rvalid_reg ? oam_rdata : 8'h00;
                        end
                        ppurp_pkg::REG_DATA:
                        begin
                            // palette reads bypass the buffer
                            if (cur_addr_reg[13:0] >= ppurp_pkg::PALETTE_BASE)
                            begin
                                rsp_next.read_data = cmd.vram_rdata;
                            end
                            else
                            begin
                                rsp_next.read_data = read_buf_reg;
                            end
                            read_buf_next     = cmd.vram_rdata;
                            rsp_next.mem_read = 1'b1;
                            cur_addr_next     = cur_addr_reg + addr_inc;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ppurp_pkg::FUNC_WRITE:
                begin
                    unique case (cmd.reg_index)
                        ppurp_pkg::REG_CTRL:
                        begin
                            control_next  = cmd.data;
                            tmp_addr_next = {tmp_addr_reg[15:12], cmd.data[1:0],
                                             tmp_addr_reg[9:0]};
                        end
                        ppurp_pkg::REG_MASK:
                        begin
                            mask_next = cmd.data;
                        end
                        ppurp_pkg::REG_OAM_ADDR:
                        begin
                            oam_addr_next = cmd.data[OAM_AW-1:0];
                        end
                        ppurp_pkg::REG_OAM_DATA:
                        begin
                            oam_we        = 1'b1;
                            oam_addr_next = oam_addr_reg + OAM_AW'(1);
                        end
                        ppurp_pkg::REG_SCROLL:
                        begin
                            if (!latch_reg)
                            begin
                                fine_x_next   = cmd.data[2:0];
                                tmp_addr_next = {tmp_addr_reg[15:5], cmd.data[7:3]};
                                latch_next    = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next = {tmp_addr_reg[15], cmd.data[2:0],
                                                 tmp_addr_reg[11:10], cmd.data[7:3],
                                                 tmp_addr_reg[4:0]};
                                latch_next    = 1'b0;
                            end
                        end
                        ppurp_pkg::REG_ADDR:
                        begin
                            if (!latch_reg)
                            begin
                                tmp_addr_next = {2'b00, cmd.data[5:0], tmp_addr_reg[7:0]};
                                latch_next    = 1'b1;
                            end
                            else
                            begin
                                tmp_addr_next = {tmp_addr_reg[15:8], cmd.data};
                                cur_addr_next = {tmp_addr_reg[15:8], cmd.data};
                                latch_next    = 1'b0;
                            end
                        end
                        ppurp_pkg::REG_DATA:
                        begin
                            rsp_next.mem_write = 1'b1;
                            rsp_next.mem_wdata = cmd.data;
                            cur_addr_next      = cur_addr_reg + addr_inc;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ppurp_pkg::FUNC_FLAGS:
                begin
                    status_next = cmd.data[7:5];
                end
                default:
                begin
                end
            endcase
        end
        rsp_next.mem_addr      = cur_addr_reg;
        rsp_next.cur_addr      = cur_addr_next;
        rsp_next.tmp_addr      = tmp_addr_next;
        rsp_next.fine_scroll_x = fine_x_next;
        rsp_next.control_byte  = control_next;
        rsp_next.mask_byte     = mask_next;
    end

    always_comb
    begin
        oam_valid_next = oam_valid_reg;
        if (oam_we)
        begin
            oam_valid_next[oam_addr_reg] = 1'b1;
        end
    end

    // read address follows the next sprite address, never equal to a write address
    ppurp_ram #(
        .WIDTH(ppurp_pkg::BYTE_W),
        .DEPTH(SPRITE_MEM_DEPTH)
    ) u_oam (
        .clk  (clk),
        .we   (oam_we),
        .waddr(oam_addr_reg),
        .wdata(cmd.data),
        .raddr(oam_addr_next),
        .rdata(oam_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= '0;
            mask_reg       <= '0;
            status_reg     <= '0;
            oam_addr_reg   <= '0;
            read_buf_reg   <= '0;
            cur_addr_reg   <= '0;
            tmp_addr_reg   <= '0;
            fine_x_reg     <= '0;
            latch_reg      <= 1'b0;
            oam_valid_reg  <= '0;
            oam_rvalid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            control_reg    <= control_next;
            mask_reg       <= mask_next;
            status_reg     <= status_next;
            oam_addr_reg   <= oam_addr_next;
            read_buf_reg   <= read_buf_next;
            cur_addr_reg   <= cur_addr_next;
            tmp_addr_reg   <= tmp_addr_next;
            fine_x_reg     <= fine_x_next;
            latch_reg      <= latch_next;
            oam_valid_reg  <= oam_valid_next;
            oam_rvalid_reg <= oam_valid_reg[oam_addr_next];
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/ppurp_checker.sv =====
// port-level assertions for the ppu register port, bound to the top level
module ppurp_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input ppurp_pkg::cmd_t cmd,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input ppurp_pkg::rsp_t rsp
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // request side stalls only behind a stalled response
    a_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled without a stalled response");

    // every accepted request yields a response next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> rsp_valid)
        else $error("accepted request without response");

    // data port accesses advance the address by one or by a row
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.mem_read || rsp.mem_write) |->
            (rsp.cur_addr == 16'(rsp.mem_addr + 16'd1)) ||
            (rsp.cur_addr == 16'(rsp.mem_addr + 16'd32)))
        else $error("data access did not advance the address");

    // a read and a write never share one response
    a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mem_read |-> !rsp.mem_write && (rsp.mem_wdata == 8'h00))
        else $error("memory read and write in one response");

endmodule

bind video_ppu_register_port_unit ppurp_checker u_ppurp_checker (.*);
